// ===== sv/fat_cluster_chain_engine_macros.svh =====
// Assertion helpers used by the engine's RTL.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_MACROS_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_MACROS_SVH

// Same-cycle implication.
`define FCCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FCCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fcce_pkg.sv =====
package fcce_pkg;

   localparam int NUM_CLUSTERS = 2048;
   localparam int IDX_W = $clog2(NUM_CLUSTERS);

   localparam logic [15:0] END_MARK    = 16'hFFFF;
   localparam logic [15:0] LIMIT_RESET = 16'd2880;
   localparam logic [15:0] NUM_CL16    = 16'(NUM_CLUSTERS);
   localparam logic [15:0] FIRST_CL    = 16'd2;
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(2);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CLUSTERS - 1);

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_ALLOC = 3'd2,
      OP_FREE  = 3'd3,
      OP_CHECK = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_NOFREE  = 3'd1,
      STAT_DIFFER  = 3'd2,
      STAT_TOOLONG = 3'd3,
      STAT_BAD     = 3'd4
   } status_type;

   localparam logic [1:0] SEL_PRIMARY = 2'd0;
   localparam logic [1:0] SEL_MIRROR  = 2'd1;
   localparam logic [1:0] SEL_BOTH    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_READ,
      ST_SCAN_START,
      ST_SCAN,
      ST_WALK_TEST,
      ST_WALK_DATA,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_primary;
      logic             wr_mirror;
      logic [IDX_W-1:0] wr_addr;
      logic [15:0]      wr_data;
   } tbl_req_type;

   typedef struct packed {
      logic [15:0] primary;
      logic [15:0] mirror;
   } tbl_rsp_type;

endpackage

// ===== sv/fcce_tables.sv =====
module fcce_tables (
   input  logic                 clock,
   input  logic                 reset,
   input  fcce_pkg::tbl_req_type tbl_req,
   output fcce_pkg::tbl_rsp_type tbl_rsp,
   output logic                 clear_busy
);
   import fcce_pkg::*;

   logic [15:0] primary_mem [NUM_CLUSTERS];
   logic [15:0] mirror_mem  [NUM_CLUSTERS];

   logic             clear_busy_ff, clear_busy_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;
   logic [15:0]      primary_q_ff, mirror_q_ff;

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_idx_in  = clear_idx_ff;
      if (clear_busy_ff) begin
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == LAST_IDX) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
      end
   end

   // sweep zeros through both copies after reset, then serve the engine
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         primary_mem[clear_idx_ff] <= '0;
         mirror_mem[clear_idx_ff]  <= '0;
      end else begin
         if (tbl_req.wr_primary) begin
            primary_mem[tbl_req.wr_addr] <= tbl_req.wr_data;
         end
         if (tbl_req.wr_mirror) begin
            mirror_mem[tbl_req.wr_addr] <= tbl_req.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      primary_q_ff <= primary_mem[tbl_req.rd_addr];
      mirror_q_ff  <= mirror_mem[tbl_req.rd_addr];
   end

   assign tbl_rsp.primary = primary_q_ff;
   assign tbl_rsp.mirror  = mirror_q_ff;
   assign clear_busy      = clear_busy_ff;

endmodule

// ===== sv/fat_cluster_chain_engine.sv =====
// From request accept to result register, a write passes ST_ACCESS then ST_RESP, a read
// ST_ACCESS, ST_READ, ST_RESP; allocate scans one entry per cycle from cluster 2; free and check walk the chain.
// One request is in work at a time; the next can be taken in the cycle after the result is registered.
// Both table copies sit on one read port and one write port; each chain step is a read
// in ST_WALK_TEST and a compare or write-back in ST_WALK_DATA.
// Reset (synchronous) zeroes both tables in a sweep over all 2048 entries; requests stall meanwhile.
`include "fat_cluster_chain_engine_macros.svh"

module fat_cluster_chain_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_cluster,
   input  logic [15:0] req_entry_value,
   input  logic [1:0]  req_copy_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_cluster,
   output logic [15:0] rsp_chain_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import fcce_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [15:0]      cl_ff, cl_in;
   logic [15:0]      val_ff, val_in;
   logic [1:0]       sel_ff, sel_in;
   logic [IDX_W-1:0] look_ff, look_in;
   logic [15:0]      walk_ff, walk_in;
   logic [15:0]      count_ff, count_in;
   status_type       stat_ff, stat_in;
   logic [15:0]      res_ff, res_in;
   logic [15:0]      limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [15:0]      rsp_result_ff, rsp_result_in;
   logic [15:0]      rsp_length_ff, rsp_length_in;

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;
   logic        clear_busy;

   logic req_fire, rsp_free, cl_bad;
   logic walk_end, walk_bad, walk_long, copies_differ, scan_hit, scan_last;

   fcce_tables u_tables (
      .clock      (clock),
      .reset      (reset),
      .tbl_req    (tbl_req),
      .tbl_rsp    (tbl_rsp),
      .clear_busy (clear_busy)
   );

   assign req_stall = (state_ff != ST_IDLE) || clear_busy;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      cl_bad        = cl_ff >= NUM_CL16;
      walk_end      = walk_ff == END_MARK;
      walk_bad      = (walk_ff < FIRST_CL) || (walk_ff >= NUM_CL16);
      walk_long     = count_ff >= limit_ff;
      copies_differ = tbl_rsp.primary != tbl_rsp.mirror;
      scan_hit      = tbl_rsp.primary == '0;
      scan_last     = look_ff == LAST_IDX;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_op))
                  OP_WRITE, OP_READ: state_in = ST_ACCESS;
                  OP_ALLOC:          state_in = ST_SCAN_START;
                  OP_FREE, OP_CHECK: state_in = ST_WALK_TEST;
                  default:           state_in = ST_RESP;
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = (op_ff == OP_READ && !cl_bad) ? ST_READ : ST_RESP;
         end
         ST_READ:       state_in = ST_RESP;
         ST_SCAN_START: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_WALK_TEST: begin
            state_in = (walk_end || walk_bad || walk_long) ? ST_RESP : ST_WALK_DATA;
         end
         ST_WALK_DATA: begin
            state_in = (op_ff == OP_CHECK && copies_differ) ? ST_RESP : ST_WALK_TEST;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table accesses
   always_comb begin
      op_in         = op_ff;
      cl_in         = cl_ff;
      val_in        = val_ff;
      sel_in        = sel_ff;
      look_in       = look_ff;
      walk_in       = walk_ff;
      count_in      = count_ff;
      stat_in       = stat_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_length_in = rsp_length_ff;
      limit_in      = (csr_valid && csr_ready) ? csr_data : limit_ff;
      tbl_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_op);
               cl_in    = req_cluster;
               val_in   = req_entry_value;
               sel_in   = req_copy_select;
               walk_in  = req_cluster;
               count_in = '0;
               stat_in  = STAT_OK;
               res_in   = '0;
            end
         end
         ST_ACCESS: begin
            tbl_req.rd_addr = cl_ff[IDX_W-1:0];
            if (cl_bad) begin
               stat_in = STAT_BAD;
            end else if (op_ff == OP_WRITE) begin
               tbl_req.wr_primary = (sel_ff == SEL_PRIMARY) || (sel_ff == SEL_BOTH);
               tbl_req.wr_mirror  = (sel_ff == SEL_MIRROR) || (sel_ff == SEL_BOTH);
               tbl_req.wr_addr    = cl_ff[IDX_W-1:0];
               tbl_req.wr_data    = val_ff;
            end
         end
         ST_READ: begin
            res_in = (sel_ff == SEL_MIRROR) ? tbl_rsp.mirror : tbl_rsp.primary;
         end
         ST_SCAN_START: begin
            tbl_req.rd_addr = FIRST_IDX;
            look_in         = FIRST_IDX;
         end
         ST_SCAN: begin
            // data on the read port belongs to look_ff; fetch the next entry meanwhile
            if (scan_hit) begin
               tbl_req.wr_primary = 1'b1;
               tbl_req.wr_mirror  = 1'b1;
               tbl_req.wr_addr    = look_ff;
               tbl_req.wr_data    = END_MARK;
               res_in             = 16'(look_ff);
            end else if (scan_last) begin
               stat_in = STAT_NOFREE;
            end else begin
               look_in         = look_ff + 1'b1;
               tbl_req.rd_addr = look_ff + 1'b1;
            end
         end
         ST_WALK_TEST: begin
            tbl_req.rd_addr = walk_ff[IDX_W-1:0];
            if (walk_end) begin
               stat_in = STAT_OK;
            end else if (walk_bad) begin
               stat_in = STAT_BAD;
            end else if (walk_long) begin
               stat_in = STAT_TOOLONG;
            end
         end
         ST_WALK_DATA: begin
            if (op_ff == OP_CHECK && copies_differ) begin
               stat_in = STAT_DIFFER;
            end else begin
               if (op_ff == OP_FREE) begin
                  tbl_req.wr_primary = 1'b1;
                  tbl_req.wr_mirror  = 1'b1;
                  tbl_req.wr_addr    = walk_ff[IDX_W-1:0];
                  tbl_req.wr_data    = '0;
               end
               count_in = count_ff + 16'd1;
               walk_in  = tbl_rsp.primary;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_result_in = res_ff;
               rsp_length_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cl_ff         <= cl_in;
      val_ff        <= val_in;
      sel_ff        <= sel_in;
      look_ff       <= look_in;
      walk_ff       <= walk_in;
      count_ff      <= count_in;
      stat_ff       <= stat_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_cluster = rsp_result_ff;
   assign rsp_chain_length   = rsp_length_ff;

   `FCCE_ASSERT_NOW(a_stall_while_clearing, clock, reset, clear_busy, req_stall, "request taken during table sweep")
   `FCCE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE, "engine idle after accepting a request")
   `FCCE_ASSERT_NOW(a_failure_has_no_cluster, clock, reset, rsp_valid_ff && rsp_status_ff != STAT_OK, rsp_result_ff == '0, "failed request carries a cluster")

endmodule
